// ----- design/cfc_pkg.sv -----
// ----------------------------------------------------------------------------
// cfc_pkg
// Shared types and constants of the codon frame counter.
// ----------------------------------------------------------------------------
package cfc_pkg;

    localparam int POS_W   = 20;
    localparam int ROW_W   = 19;
    localparam int COL_W   = 7;
    localparam int QUAL_W  = 7;
    localparam int CODE_W  = 3;
    localparam int FRAMES  = 3;
    localparam int NCOLS   = 66;
    localparam int QDEPTH  = 4;

    // reciprocal of 3 scaled by 2^21, exact for 20-bit operands
    localparam logic [19:0] RECIP3 = 20'd699051;

    localparam logic [CODE_W-1:0] CODE_N   = 3'd4;
    localparam logic [CODE_W-1:0] CODE_GAP = 3'd5;

    localparam logic [COL_W-1:0] COL_GAP   = 7'd64;
    localparam logic [COL_W-1:0] COL_OTHER = 7'd65;

    localparam logic [1:0] ST_COUNTED = 2'd0;
    localparam logic [1:0] ST_DUP     = 2'd1;
    localparam logic [1:0] ST_RANGE   = 2'd2;

    localparam logic [6:0] THR_RESET  = 7'd30;
    localparam logic       REG_THR    = 1'b0;

    typedef struct packed {
        logic             valid;
        logic [1:0]       frame;
        logic [ROW_W-1:0] row;
        logic [COL_W-1:0] col;
        logic [1:0]       status;
    } cfc_event_t;

    typedef struct packed {
        cfc_event_t [FRAMES-1:0] ev;
    } cfc_bundle_t;

endpackage

// ----- design/cfc_front.sv -----
// ----------------------------------------------------------------------------
// cfc_front
// Takes bases, works out codon rows and forms codons in three frames.
// ----------------------------------------------------------------------------
module cfc_front import cfc_pkg::*; #(
    parameter int CODON_ROWS = 8192
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              clr_busy,
    input  logic              s_valid,
    output logic              s_ready,
    input  logic [2:0]        s_base_code,
    input  logic [19:0]       s_ref_pos,
    input  logic [6:0]        s_base_quality,
    input  logic              s_read_end,
    input  logic [6:0]        threshold,
    input  logic              q_full,
    output logic              push,
    output cfc_bundle_t       push_bundle
);

    typedef struct packed {
        logic [CODE_W-1:0] code;
        logic [POS_W-1:0]  pos;
        logic [QUAL_W-1:0] qual;
        logic [ROW_W-1:0]  row;
        logic [1:0]        phase;
        logic              pz;
    } base_t;

    logic              a_valid_reg;
    logic [CODE_W-1:0] a_code_reg;
    logic [POS_W-1:0]  a_pos_reg;
    logic [QUAL_W-1:0] a_qual_reg;
    logic              a_end_reg;
    logic [ROW_W-1:0]  a_q_reg;

    base_t             pb_reg [FRAMES][2];
    base_t             pb_next [FRAMES][2];
    logic [1:0]        pcnt_reg [FRAMES];
    logic [1:0]        pcnt_next [FRAMES];
    logic [ROW_W-1:0]  lrow_reg [FRAMES];
    logic [ROW_W-1:0]  lrow_next [FRAMES];
    logic [FRAMES-1:0] lrv_reg;
    logic [FRAMES-1:0] lrv_next;

    logic [POS_W-1:0]  pos_m1;
    logic [39:0]       prod;
    logic [POS_W-1:0]  three_q;
    base_t             nb;
    logic              b_go;

    function automatic logic starts(base_t b, int f);
        return !b.pz && (b.phase == 2'(f));
    endfunction

    function automatic logic [COL_W-1:0] col_of(base_t b0, base_t b1, base_t b2);
        if (b0.code == CODE_GAP && b1.code == CODE_GAP && b2.code == CODE_GAP) begin
            return COL_GAP;
        end else if (b0.code < CODE_N && b1.code < CODE_N && b2.code < CODE_N) begin
            return {1'b0, b0.code[1:0], b1.code[1:0], b2.code[1:0]};
        end
        return COL_OTHER;
    endfunction

    assign pos_m1  = s_ref_pos - 20'd1;
    assign prod    = {20'd0, pos_m1} * {20'd0, RECIP3};
    assign s_ready = !clr_busy && (!a_valid_reg || !q_full);
    assign b_go    = a_valid_reg && !q_full;

    assign three_q  = {1'b0, a_q_reg} + {a_q_reg, 1'b0};
    assign nb.code  = a_code_reg;
    assign nb.pos   = a_pos_reg;
    assign nb.qual  = a_qual_reg;
    assign nb.row   = a_q_reg + 19'd1;
    assign nb.phase = 2'(a_pos_reg - 20'd1 - three_q);
    assign nb.pz    = (a_pos_reg == '0);

    always_comb begin
        base_t w0, w1, w2;
        logic  brk;
        for (int f = 0; f < FRAMES; f++) begin
            pb_next[f][0] = pb_reg[f][0];
            pb_next[f][1] = pb_reg[f][1];
            pcnt_next[f]  = pcnt_reg[f];
            lrow_next[f]  = lrow_reg[f];
            lrv_next[f]   = lrv_reg[f];
            push_bundle.ev[f] = '0;
            push_bundle.ev[f].frame = 2'(f);
            w0 = pb_reg[f][0];
            w1 = pb_reg[f][1];
            w2 = nb;
            brk = ({1'b0, w1.pos} > {1'b0, w0.pos} + 21'd1) ||
                  ({1'b0, w2.pos} > {1'b0, w1.pos} + 21'd1);
            unique case (pcnt_reg[f])
                2'd0: begin
                    if (starts(nb, f)) begin
                        pb_next[f][0] = nb;
                        pcnt_next[f]  = 2'd1;
                    end
                end
                2'd1: begin
                    pb_next[f][1] = nb;
                    pcnt_next[f]  = 2'd2;
                end
                default: begin
                    pcnt_next[f] = 2'd0;
                    if (brk) begin
                        // drop the first base and look for a new start
                        if (starts(w1, f)) begin
                            pb_next[f][0] = w1;
                            pb_next[f][1] = w2;
                            pcnt_next[f]  = 2'd2;
                        end else if (starts(w2, f)) begin
                            pb_next[f][0] = w2;
                            pcnt_next[f]  = 2'd1;
                        end
                    end else if (w0.qual >= threshold && w1.qual >= threshold &&
                                 w2.qual >= threshold) begin
                        push_bundle.ev[f].valid = 1'b1;
                        push_bundle.ev[f].row   = w0.row;
                        push_bundle.ev[f].col   = col_of(w0, w1, w2);
                        if (lrv_reg[f] && lrow_reg[f] == w0.row) begin
                            push_bundle.ev[f].status = ST_DUP;
                        end else if ({1'b0, w0.row} >= 20'(CODON_ROWS)) begin
                            push_bundle.ev[f].status = ST_RANGE;
                        end else begin
                            push_bundle.ev[f].status = ST_COUNTED;
                        end
                        lrow_next[f] = w0.row;
                        lrv_next[f]  = 1'b1;
                    end
                end
            endcase
            if (a_end_reg) begin
                pcnt_next[f] = 2'd0;
                lrv_next[f]  = 1'b0;
            end
        end
    end

    assign push = b_go && (push_bundle.ev[0].valid || push_bundle.ev[1].valid ||
                           push_bundle.ev[2].valid);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            a_valid_reg <= 1'b0;
            lrv_reg     <= '0;
            for (int f = 0; f < FRAMES; f++) begin
                pcnt_reg[f] <= 2'd0;
            end
        end else begin
            if (s_ready) begin
                a_valid_reg <= s_valid;
            end
            if (b_go) begin
                lrv_reg <= lrv_next;
                for (int f = 0; f < FRAMES; f++) begin
                    pcnt_reg[f] <= pcnt_next[f];
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            a_code_reg <= s_base_code;
            a_pos_reg  <= s_ref_pos;
            a_qual_reg <= s_base_quality;
            a_end_reg  <= s_read_end;
            a_q_reg    <= prod[39:21];
        end
        if (b_go) begin
            for (int f = 0; f < FRAMES; f++) begin
                pb_reg[f][0] <= pb_next[f][0];
                pb_reg[f][1] <= pb_next[f][1];
                lrow_reg[f]  <= lrow_next[f];
            end
        end
    end

endmodule

// ----- design/cfc_queue.sv -----
// ----------------------------------------------------------------------------
// cfc_queue
// Short queue of codon bundles between the front and the counter stage.
// ----------------------------------------------------------------------------
module cfc_queue import cfc_pkg::*; (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        push,
    input  cfc_bundle_t push_bundle,
    output logic        full,
    input  logic        pop,
    output logic        head_valid,
    output cfc_bundle_t head
);

    localparam int PW = $clog2(QDEPTH);

    cfc_bundle_t   mem_reg [QDEPTH];
    logic [PW-1:0] wr_ptr_reg;
    logic [PW-1:0] rd_ptr_reg;
    logic [PW:0]   cnt_reg;

    assign full       = (cnt_reg == (PW+1)'(QDEPTH));
    assign head_valid = (cnt_reg != '0);
    assign head       = mem_reg[rd_ptr_reg];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end else begin
            if (push) begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (pop) begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            cnt_reg <= cnt_reg + (PW+1)'(push) - (PW+1)'(pop);
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            mem_reg[wr_ptr_reg] <= push_bundle;
        end
    end

endmodule

// ----- design/cfc_back.sv -----
// ----------------------------------------------------------------------------
// cfc_back
// Counter banks, one per frame, with read-modify-write and result register.
// ----------------------------------------------------------------------------
module cfc_back import cfc_pkg::*; #(
    parameter int CODON_ROWS = 8192,
    parameter int COUNT_BITS = 32
) (
    input  logic              aclk,
    input  logic              aresetn,
    output logic              clr_busy,
    input  logic              head_valid,
    input  cfc_bundle_t       head,
    output logic              pop,
    output logic              m_valid,
    input  logic              m_ready,
    output logic [1:0]        m_frame,
    output logic [18:0]       m_codon_row,
    output logic [6:0]        m_codon_column,
    output logic [31:0]       m_new_count,
    output logic [1:0]        m_status,
    output logic              m_last_result
);

    localparam int DEPTH = CODON_ROWS * NCOLS;
    localparam int AW    = $clog2(DEPTH);
    localparam logic [COUNT_BITS-1:0] CMAX = {COUNT_BITS{1'b1}};

    logic [COUNT_BITS-1:0] bank0 [DEPTH];
    logic [COUNT_BITS-1:0] bank1 [DEPTH];
    logic [COUNT_BITS-1:0] bank2 [DEPTH];
    logic [COUNT_BITS-1:0] rd_reg [FRAMES];

    logic                  clr_reg;
    logic [AW-1:0]         clr_addr_reg;

    logic [FRAMES-1:0]     done_reg;
    logic [FRAMES-1:0]     pend;
    logic [1:0]            sel;
    logic                  sel_last;
    cfc_event_t            ev;
    logic [25:0]           addr_wide;
    logic [AW-1:0]         ev_addr;
    logic                  issue;

    logic                  x_valid_reg;
    cfc_event_t            x_ev_reg;
    logic                  x_last_reg;
    logic [AW-1:0]         x_addr_reg;
    logic                  x_fwd_reg;
    logic [COUNT_BITS-1:0] x_fwd_data_reg;
    logic                  x_fire;
    logic                  x_wr;
    logic [COUNT_BITS-1:0] base_cnt;
    logic [COUNT_BITS-1:0] new_cnt;

    logic                  o_valid_reg;

    assign clr_busy = clr_reg;

    always_comb begin
        pend = {head.ev[2].valid, head.ev[1].valid, head.ev[0].valid} & ~done_reg;
        priority if (pend[0]) begin
            sel = 2'd0;
        end else if (pend[1]) begin
            sel = 2'd1;
        end else begin
            sel = 2'd2;
        end
        unique case (sel)
            2'd0:    sel_last = !pend[1] && !pend[2];
            2'd1:    sel_last = !pend[2];
            default: sel_last = 1'b1;
        endcase
        ev = head.ev[sel];
    end

    // row * 66 + column
    assign addr_wide = {1'b0, ev.row, 6'd0} + {6'd0, ev.row, 1'b0} + {19'd0, ev.col};
    assign ev_addr   = AW'(addr_wide);

    assign x_fire = x_valid_reg && (!o_valid_reg || m_ready);
    assign x_wr   = x_fire && x_ev_reg.status == ST_COUNTED;
    assign issue  = head_valid && !clr_reg && (!x_valid_reg || x_fire);
    assign pop    = issue && sel_last;

    assign base_cnt = x_fwd_reg ? x_fwd_data_reg : rd_reg[x_ev_reg.frame];
    assign new_cnt  = (base_cnt == CMAX) ? base_cnt : base_cnt + 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            clr_reg      <= 1'b1;
            clr_addr_reg <= '0;
            done_reg     <= '0;
            x_valid_reg  <= 1'b0;
            o_valid_reg  <= 1'b0;
        end else begin
            if (clr_reg) begin
                clr_addr_reg <= clr_addr_reg + 1'b1;
                if (clr_addr_reg == AW'(DEPTH - 1)) begin
                    clr_reg <= 1'b0;
                end
            end
            if (pop) begin
                done_reg <= '0;
            end else if (issue) begin
                done_reg[sel] <= 1'b1;
            end
            if (issue) begin
                x_valid_reg <= 1'b1;
            end else if (x_fire) begin
                x_valid_reg <= 1'b0;
            end
            if (x_fire) begin
                o_valid_reg <= 1'b1;
            end else if (m_ready) begin
                o_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (issue) begin
            x_ev_reg       <= ev;
            x_last_reg     <= sel_last;
            x_addr_reg     <= ev_addr;
            // a write at this same edge is not seen by the read
            x_fwd_reg      <= x_wr && x_ev_reg.frame == ev.frame && x_addr_reg == ev_addr;
            x_fwd_data_reg <= new_cnt;
            rd_reg[0]      <= bank0[ev_addr];
            rd_reg[1]      <= bank1[ev_addr];
            rd_reg[2]      <= bank2[ev_addr];
        end
        if (x_fire) begin
            m_frame        <= x_ev_reg.frame;
            m_codon_row    <= x_ev_reg.row;
            m_codon_column <= x_ev_reg.col;
            m_status       <= x_ev_reg.status;
            m_last_result  <= x_last_reg;
            m_new_count    <= (x_ev_reg.status == ST_COUNTED) ? 32'(new_cnt) : 32'd0;
        end
    end

    always_ff @(posedge aclk) begin
        if (clr_reg) begin
            bank0[clr_addr_reg] <= '0;
        end else if (x_wr && x_ev_reg.frame == 2'd0) begin
            bank0[x_addr_reg] <= new_cnt;
        end
    end

    always_ff @(posedge aclk) begin
        if (clr_reg) begin
            bank1[clr_addr_reg] <= '0;
        end else if (x_wr && x_ev_reg.frame == 2'd1) begin
            bank1[x_addr_reg] <= new_cnt;
        end
    end

    always_ff @(posedge aclk) begin
        if (clr_reg) begin
            bank2[clr_addr_reg] <= '0;
        end else if (x_wr && x_ev_reg.frame == 2'd2) begin
            bank2[x_addr_reg] <= new_cnt;
        end
    end

    assign m_valid = o_valid_reg;

endmodule

// ----- design/codon_frame_counter.sv -----
// ----------------------------------------------------------------------------
// codon_frame_counter
// Counts codons of aligned reads in three reading frames.
// ----------------------------------------------------------------------------
// Bases enter on the s_ channel, one transfer per base, and may follow every
// cycle while the queue has room. Each completed codon whose three bases all
// meet the threshold yields one transfer on the m_ channel: its frame, row,
// column, saturated count and status; m_last_result marks the last transfer
// caused by one base. A base causes zero to three transfers, one per codon,
// and passes through the input register, the queue, the read register and
// the result register. Results leave one per cycle while the receiver is
// ready. Each frame has its own counter bank, one read-modify-write per
// counted result, with back-to-back updates of one counter forwarded.
// After reset the banks are swept to zero with s_ready low; the threshold
// register may be written meanwhile. When the receiver stalls, up to four
// bases with codons wait in the queue, one more in the input register, then
// s_ready drops. quality_threshold lies at byte address 0.
// ----------------------------------------------------------------------------
module codon_frame_counter import cfc_pkg::*; #(
    parameter int CODON_ROWS = 8192,
    parameter int COUNT_BITS = 32
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [2:0]  s_base_code,
    input  logic [19:0] s_ref_pos,
    input  logic [6:0]  s_base_quality,
    input  logic        s_read_end,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [1:0]  m_frame,
    output logic [18:0] m_codon_row,
    output logic [6:0]  m_codon_column,
    output logic [31:0] m_new_count,
    output logic [1:0]  m_status,
    output logic        m_last_result
);

    logic [6:0]  thr_reg;
    logic        clr_busy;
    logic        q_full;
    logic        push;
    cfc_bundle_t push_bundle;
    logic        pop;
    logic        head_valid;
    cfc_bundle_t head;

    assign pready = 1'b1;
    assign prdata = (paddr[2] == REG_THR) ? {25'd0, thr_reg} : 32'd0;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            thr_reg <= THR_RESET;
        end else if (psel && penable && pwrite && paddr[2] == REG_THR) begin
            thr_reg <= pwdata[6:0];
        end
    end

    cfc_front #(.CODON_ROWS(CODON_ROWS)) u_front (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .clr_busy      (clr_busy),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_base_code   (s_base_code),
        .s_ref_pos     (s_ref_pos),
        .s_base_quality(s_base_quality),
        .s_read_end    (s_read_end),
        .threshold     (thr_reg),
        .q_full        (q_full),
        .push          (push),
        .push_bundle   (push_bundle)
    );

    cfc_queue u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push       (push),
        .push_bundle(push_bundle),
        .full       (q_full),
        .pop        (pop),
        .head_valid (head_valid),
        .head       (head)
    );

    cfc_back #(.CODON_ROWS(CODON_ROWS), .COUNT_BITS(COUNT_BITS)) u_back (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .clr_busy      (clr_busy),
        .head_valid    (head_valid),
        .head          (head),
        .pop           (pop),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_frame       (m_frame),
        .m_codon_row   (m_codon_row),
        .m_codon_column(m_codon_column),
        .m_new_count   (m_new_count),
        .m_status      (m_status),
        .m_last_result (m_last_result)
    );

`ifndef SYNTHESIS
    a_no_input_while_clearing: assert property (@(posedge aclk) disable iff (!aresetn)
        clr_busy |-> !s_ready)
        else $error("input taken during counter sweep");

    a_counted_nonzero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_status == ST_COUNTED) |-> (m_new_count != 32'd0))
        else $error("counted codon with zero count");

    a_flagged_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_status != ST_COUNTED) |-> (m_new_count == 32'd0))
        else $error("flagged codon with nonzero count");
`endif

endmodule
